// ===== rtl/core/gve_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the grid velocity extrapolation unit.
// No dependencies; the datapath, the controller and the top level import this package.
package gve_pkg;

    // Grid geometry and value width defaults
    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Register indexes and reset values
    localparam logic [1:0] CFG_GRID_COLS   = 2'd0;
    localparam logic [1:0] CFG_GRID_ROWS   = 2'd1;
    localparam logic [1:0] CFG_LAYER_LIMIT = 2'd2;
    localparam logic [6:0] GRID_COLS_RST   = 7'd64;
    localparam logic [6:0] GRID_ROWS_RST   = 7'd64;
    localparam logic [3:0] LAYER_LIMIT_RST = 4'd10;

    // Input word
    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] cell_value;
        logic               cell_valid;
    } item_t;

    // Result word
    typedef struct packed {
        logic signed [31:0] out_value;
        logic               out_valid;
        logic [3:0]         layers_done;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic item_write;
        logic item_read;
        logic out_zero;
        logic out_read;
        logic out_run;
        logic run_init;
        logic layer_init;
        logic nb_step;
        logic div_start;
        logic cell_write;
        logic layer_commit;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic run_over;
        logic nb_last;
        logic need_div;
        logic div_busy;
        logic cell_last;
    } sts_t;

endpackage

// ===== rtl/core/gve_div.sv =====
`timescale 1ns / 1ps
// Restoring divider: unsigned magnitude over a 1..4 neighbour count, one bit a cycle.
// Depends on nothing; used by gve_datapath.
module gve_div #(
    parameter int W = 34
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [2:0]   divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [2:0]    rem_reg, rem_next;
    logic [2:0]    den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]    trial;

    // One quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        quo_next = {quo_reg[W-2:0], 1'b0};
        rem_next = trial[2:0];
        cnt_next = cnt_reg;
        if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = 3'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(W);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/gve_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: cell stores, scan counters, neighbour accumulation and result register.
// Depends on gve_pkg and gve_div.
module gve_datapath #(
    parameter int MAX_COLS   = gve_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = gve_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = gve_pkg::VALUE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gve_pkg::cmd_t   cmd,
    output gve_pkg::sts_t   sts,
    input  gve_pkg::item_t  item,
    input  logic [6:0]      grid_cols,
    input  logic [6:0]      grid_rows,
    input  logic [3:0]      layer_limit,
    output gve_pkg::result_t result
);
    import gve_pkg::*;

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int MAXD   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int UW0    = $clog2(MAXD + 1);
    localparam int UW     = (UW0 > 7) ? UW0 : 7;
    localparam int VB     = VALUE_BITS;
    localparam int SW     = VB + 2;
    localparam logic [2:0] NB_LAST = 3'd5;

    // Cell stores: value, and valid mark in two banks.
    // At rest a cell's mark is the OR of its two bits; during a layer the
    // cells already scanned hold their prior mark in the current bank.
    logic [VB-1:0] value_mem [CELLS];
    logic [1:0]    valid_mem [CELLS];

    logic [VB-1:0] val_rd_reg;
    logic [1:0]    vld_rd_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] vwr_addr;
    logic [1:0]    vwr_data;
    logic          vwr_en;
    logic          valwr_en;
    logic [VB-1:0] valwr_data;

    logic [AW-1:0] clr_reg;
    logic          bank_reg;
    logic [3:0]    layer_reg;
    logic [3:0]    done_reg;
    logic          stop_reg;
    logic          filled_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [2:0]    step_reg;
    logic [SW-1:0] sum_reg;
    logic [2:0]    cnt_reg;
    logic [1:0]    ctr_word_reg;
    logic          inside_reg;
    result_t       res_reg;

    logic [UW-1:0] used_cols, used_rows;
    logic          addr_ok;
    logic          no_interior;
    logic [AW-1:0] item_addr, ctr_addr, nb_addr;
    logic          ctr_valid;
    logic          nb_vld;
    logic          row_end, col_end;
    logic          sum_neg;
    logic [SW-1:0] mag;
    logic [SW-1:0] quo;
    logic [SW-1:0] avg;
    logic          div_busy;

    // In-use grid size and address decode
    always_comb
    begin
        used_cols   = (UW'(grid_cols) > UW'(MAX_COLS)) ? UW'(MAX_COLS) : UW'(grid_cols);
        used_rows   = (UW'(grid_rows) > UW'(MAX_ROWS)) ? UW'(MAX_ROWS) : UW'(grid_rows);
        addr_ok     = (UW'(item.row) < used_rows) && (UW'(item.col) < used_cols);
        no_interior = (used_rows < UW'(3)) || (used_cols < UW'(3));
        item_addr   = AW'(AW'(item.row) * AW'(MAX_COLS)) + AW'(item.col);
        ctr_addr    = AW'(AW'(row_reg) * AW'(MAX_COLS)) + AW'(col_reg);
        col_end     = (UW'(col_reg) == used_cols - UW'(2));
        row_end     = (UW'(row_reg) == used_rows - UW'(2));
        ctr_valid   = |ctr_word_reg;
    end

    // Neighbour address for the current step: centre, south, north, east, west
    always_comb
    begin
        case (step_reg)
            3'd0:    nb_addr = ctr_addr;
            3'd1:    nb_addr = ctr_addr + AW'(MAX_COLS);
            3'd2:    nb_addr = ctr_addr - AW'(MAX_COLS);
            3'd3:    nb_addr = ctr_addr + AW'(1);
            3'd4:    nb_addr = ctr_addr - AW'(1);
            default: nb_addr = ctr_addr;
        endcase
        rd_addr = cmd.item_read ? item_addr : nb_addr;
    end

    // Prior mark of the neighbour just read: north and west cells already
    // scanned in this layer use the current bank, all others the OR
    always_comb
    begin
        case (step_reg)
            3'd3:    nb_vld = (row_reg != RW'(1)) ? vld_rd_reg[bank_reg] : |vld_rd_reg;
            3'd5:    nb_vld = (col_reg != CW'(1)) ? vld_rd_reg[bank_reg] : |vld_rd_reg;
            default: nb_vld = |vld_rd_reg;
        endcase
    end

    // Average: magnitude through the divider, sign put back after
    assign sum_neg = sum_reg[SW-1];
    assign mag     = sum_neg ? (~sum_reg + SW'(1)) : sum_reg;
    assign avg     = sum_neg ? (~quo + SW'(1)) : quo;

    gve_div #(
        .W (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    // Store write selection
    always_comb
    begin
        vwr_en     = 1'b0;
        vwr_addr   = ctr_addr;
        vwr_data   = '0;
        valwr_en   = 1'b0;
        valwr_data = VB'(item.cell_value);
        if (cmd.clear_step)
        begin
            vwr_en   = 1'b1;
            vwr_addr = clr_reg;
        end
        else if (cmd.item_write && addr_ok)
        begin
            vwr_en   = 1'b1;
            vwr_addr = item_addr;
            vwr_data = {2{item.cell_valid}};
            valwr_en = 1'b1;
        end
        else if (cmd.cell_write)
        begin
            vwr_en                = 1'b1;
            vwr_data[bank_reg]    = ctr_valid;
            vwr_data[~bank_reg]   = ctr_valid || sts.need_div;
            valwr_en              = sts.need_div;
            valwr_data            = VB'(avg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            valid_mem[vwr_addr] <= vwr_data;
        end
        if (valwr_en)
        begin
            value_mem[vwr_addr] <= valwr_data;
        end
        vld_rd_reg <= valid_mem[rd_addr];
        val_rd_reg <= value_mem[rd_addr];
    end

    // Control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            bank_reg   <= 1'b0;
            layer_reg  <= '0;
            done_reg   <= '0;
            stop_reg   <= 1'b0;
            filled_reg <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            step_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.run_init)
            begin
                layer_reg <= '0;
                done_reg  <= '0;
                stop_reg  <= 1'b0;
            end
            if (cmd.layer_init)
            begin
                row_reg    <= RW'(1);
                col_reg    <= CW'(1);
                step_reg   <= '0;
                filled_reg <= 1'b0;
            end
            if (cmd.nb_step)
            begin
                step_reg <= step_reg + 3'd1;
            end
            if (cmd.cell_write)
            begin
                step_reg <= '0;
                if (sts.need_div)
                begin
                    filled_reg <= 1'b1;
                end
                if (col_end)
                begin
                    col_reg <= CW'(1);
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (cmd.layer_commit)
            begin
                if (filled_reg)
                begin
                    bank_reg  <= ~bank_reg;
                    done_reg  <= done_reg + 4'd1;
                    layer_reg <= layer_reg + 4'd1;
                end
                else
                begin
                    stop_reg <= 1'b1;
                end
            end
        end
    end

    // Neighbour accumulation; read data is registered and arrives in the cycle after its address
    always_ff @(posedge clk)
    begin
        if (cmd.layer_init || cmd.cell_write)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.nb_step && step_reg != 3'd0)
        begin
            if (step_reg == 3'd1)
            begin
                ctr_word_reg <= vld_rd_reg;
            end
            else if (nb_vld)
            begin
                sum_reg <= sum_reg + SW'($signed(val_rd_reg));
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
        if (cmd.item_read)
        begin
            inside_reg <= addr_ok;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_zero)
        begin
            res_reg <= '0;
        end
        else if (cmd.out_read)
        begin
            res_reg <= '0;
            if (inside_reg)
            begin
                res_reg.out_value <= 32'($signed(val_rd_reg));
                res_reg.out_valid <= |vld_rd_reg;
            end
        end
        else if (cmd.out_run)
        begin
            res_reg             <= '0;
            res_reg.layers_done <= done_reg;
        end
    end

    assign result = res_reg;

    // Status
    always_comb
    begin
        sts.clear_last = (clr_reg == AW'(CELLS - 1));
        sts.run_over   = stop_reg || no_interior || (layer_reg == layer_limit);
        sts.nb_last    = (step_reg == NB_LAST);
        sts.need_div   = !ctr_valid && (cnt_reg != 3'd0);
        sts.div_busy   = div_busy;
        sts.cell_last  = row_end && col_end;
    end

endmodule

// ===== rtl/core/gve_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences store clearing, item handling and the layer scan.
// Depends on gve_pkg.
module gve_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  logic [1:0]    action,
    output logic          result_valid,
    input  logic          result_ready,
    output gve_pkg::cmd_t cmd,
    input  gve_pkg::sts_t sts
);
    import gve_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_RUN_CHECK,
        ST_CELL_RD,
        ST_DIV_GO,
        ST_DIV,
        ST_CELL_WR,
        ST_LAYER_END
    } state_t;

    state_t state_reg, state_next;
    logic   res_vld_reg, res_vld_next;
    logic   accept;

    assign item_ready   = (state_reg == ST_IDLE) && (!res_vld_reg || result_ready);
    assign accept       = item_valid && item_ready;
    assign result_valid = res_vld_reg;

    // Next state and commands
    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        res_vld_next = res_vld_reg && !result_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_WRITE:
                        begin
                            cmd.item_write = 1'b1;
                            cmd.out_zero   = 1'b1;
                            res_vld_next   = 1'b1;
                        end
                        ACT_READ:
                        begin
                            cmd.item_read = 1'b1;
                            state_next    = ST_RD_WAIT;
                        end
                        ACT_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            state_next   = ST_RUN_CHECK;
                        end
                        default:
                        begin
                            cmd.out_zero = 1'b1;
                            res_vld_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                cmd.out_read = 1'b1;
                res_vld_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RUN_CHECK:
            begin
                if (sts.run_over)
                begin
                    cmd.out_run  = 1'b1;
                    res_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.layer_init = 1'b1;
                    state_next     = ST_CELL_RD;
                end
            end
            ST_CELL_RD:
            begin
                cmd.nb_step = 1'b1;
                if (sts.nb_last)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_CELL_WR;
                end
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_CELL_WR;
                end
            end
            ST_CELL_WR:
            begin
                cmd.cell_write = 1'b1;
                state_next     = sts.cell_last ? ST_LAYER_END : ST_CELL_RD;
            end
            ST_LAYER_END:
            begin
                cmd.layer_commit = 1'b1;
                state_next       = ST_RUN_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_vld_reg <= res_vld_next;
        end
    end

endmodule

// ===== rtl/core/grid_velocity_extrapolation_unit.sv =====
`timescale 1ns / 1ps
// Grid velocity extrapolation unit. Each write, read or run word returns one result.
// Run word: layer by layer, each interior cell reads the store port once per neighbour and,
// when it fills, then runs a bit-serial divider. One word is in flight at a time. After
// reset the valid marks of all MAX_ROWS*MAX_COLS cells (4096 by default) are cleared
// before the first word is accepted.
module grid_velocity_extrapolation_unit #(
    parameter int MAX_COLS   = gve_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = gve_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = gve_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  gve_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output gve_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data
);
    import gve_pkg::*;

    logic [6:0] grid_cols_reg;
    logic [6:0] grid_rows_reg;
    logic [3:0] layer_limit_reg;
    cmd_t       cmd;
    sts_t       sts;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg   <= GRID_COLS_RST;
            grid_rows_reg   <= GRID_ROWS_RST;
            layer_limit_reg <= LAYER_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_COLS:   grid_cols_reg   <= cfg_data;
                CFG_GRID_ROWS:   grid_rows_reg   <= cfg_data;
                CFG_LAYER_LIMIT: layer_limit_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    gve_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (item.action),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    gve_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .item        (item),
        .grid_cols   (grid_cols_reg),
        .grid_rows   (grid_rows_reg),
        .layer_limit (layer_limit_reg),
        .result      (result)
    );

endmodule
